// File: hw/rtl/mlta_pkg.sv
package mlta_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int PORT_COUNT  = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int MAC_W       = 48;
   localparam int PORT_W      = 4;
   localparam int TIME_W      = 32;
   localparam int CMDQ_DEPTH  = 2;

   localparam logic [1:0] CMD_OBSERVE = 2'd0;
   localparam logic [1:0] CMD_TICK    = 2'd1;
   localparam logic [1:0] CMD_REMOVE  = 2'd2;

   localparam logic [1:0] KIND_DISCOVERED  = 2'd0;
   localparam logic [1:0] KIND_DISAPPEARED = 2'd1;
   localparam logic [1:0] KIND_FULL        = 2'd2;

   localparam logic [2:0] REG_MAX_AGE   = 3'd0;
   localparam logic [2:0] REG_IGNORE    = 3'd1;
   localparam logic [2:0] REG_OWN_COUNT = 3'd2;
   localparam logic [2:0] REG_OWN_MAC0  = 3'd3;
   localparam logic [2:0] REG_OWN_MAC1  = 3'd4;
   localparam logic [2:0] REG_OWN_MAC2  = 3'd5;
   localparam logic [2:0] REG_OWN_MAC3  = 3'd6;

   // classified work item passed from front to back
   typedef struct packed {
      logic [1:0]        op;
      logic [MAC_W-1:0]  mac;
      logic [PORT_W-1:0] port;
   } work_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [MAC_W-1:0]  mac;
      logic [PORT_W-1:0] port;
      logic              last;
   } event_type;

endpackage

// File: hw/rtl/mlta_front.sv
module mlta_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [47:0]               csr_wdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [55:0]               req_tdata,
   output logic                      q_valid,
   input  logic                      q_ready,
   output mlta_pkg::work_type        q_item,
   output logic [31:0]               max_age
);
   import mlta_pkg::*;

   logic [31:0]       max_age_ff;
   logic              ignore_ff;
   logic [2:0]        own_count_ff;
   logic [MAC_W-1:0]  own_mac_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff   <= 32'd300;
         ignore_ff    <= 1'b1;
         own_count_ff <= 3'd0;
         for (int i = 0; i < 4; i++) own_mac_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MAX_AGE:   max_age_ff    <= csr_wdata[31:0];
            REG_IGNORE:    ignore_ff     <= csr_wdata[0];
            REG_OWN_COUNT: own_count_ff  <= csr_wdata[2:0];
            REG_OWN_MAC0:  own_mac_ff[0] <= csr_wdata;
            REG_OWN_MAC1:  own_mac_ff[1] <= csr_wdata;
            REG_OWN_MAC2:  own_mac_ff[2] <= csr_wdata;
            REG_OWN_MAC3:  own_mac_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end
   assign max_age = max_age_ff;

   logic [1:0]        cmd;
   logic [MAC_W-1:0]  mac;
   logic [PORT_W-1:0] port;
   logic              own_hit;
   logic              keep;
   assign cmd  = req_tdata[1:0];
   assign mac  = req_tdata[49:2];
   assign port = req_tdata[53:50];

   always_comb begin
      own_hit = 1'b0;
      for (int i = 0; i < 4; i++)
         if ((own_count_ff > 3'(i)) && own_mac_ff[i] == mac) own_hit = 1'b1;
      case (cmd)
         CMD_OBSERVE: keep = (mac != '0) && (mac != '1) && !(ignore_ff && own_hit);
         CMD_TICK:    keep = 1'b1;
         CMD_REMOVE:  keep = 1'b1;
         default:     keep = 1'b0;
      endcase
   end

   // small fifo of classified work
   work_type         q_mem_ff [CMDQ_DEPTH];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;
   logic             push, pop;

   assign req_tready = (cnt_ff != 2'(CMDQ_DEPTH));
   assign push = req_tvalid && req_tready && keep;
   assign pop  = q_valid && q_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = q_mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) q_mem_ff[wp_ff] <= '{op: cmd, mac: mac, port: port};
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// File: hw/rtl/mlta_back.sv
module mlta_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  mlta_pkg::work_type   q_item,
   input  logic [31:0]          max_age,
   output logic                 ev_valid,
   input  logic                 ev_ready,
   output mlta_pkg::event_type  ev
);
   import mlta_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [MAC_W-1:0]       emac_ff  [TABLE_DEPTH];
   logic [PORT_W-1:0]      eport_ff [TABLE_DEPTH];
   logic [TIME_W-1:0]      etime_ff [TABLE_DEPTH];
   logic [TIME_W-1:0]      time_ff, time_in;
   logic [1:0]             state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   work_type               cur_ff, cur_in;
   logic                   pend_ff, pend_in;
   event_type              pev_ff, pev_in;
   logic                   ev_valid_ff, ev_valid_in;
   event_type              ev_ff, ev_in;

   logic [TABLE_DEPTH-1:0] hit;
   logic                   free_found;
   logic [IDX_W-1:0]       free_idx;
   logic                   wr_en, refresh;
   logic [IDX_W-1:0]       wr_idx;
   logic                   match, out_free;
   logic [TIME_W-1:0]      age;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit[i] = valid_ff[i] && emac_ff[i] == q_item.mac && eport_ff[i] == q_item.port;
         if (!valid_ff[i] && !free_found) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign out_free = !ev_valid_ff || ev_ready;
   assign age = time_ff - etime_ff[idx_ff];
   always_comb begin
      if (cur_ff.op == CMD_TICK) match = valid_ff[idx_ff] && (age > max_age);
      else match = valid_ff[idx_ff] && eport_ff[idx_ff] == cur_ff.port;
   end

   assign q_ready = (state_ff == ST_IDLE) && out_free;

   always_comb begin
      valid_in = valid_ff; time_in = time_ff; state_in = state_ff;
      idx_in = idx_ff; cur_in = cur_ff; pend_in = pend_ff; pev_in = pev_ff;
      ev_valid_in = ev_valid_ff && !ev_ready; ev_in = ev_ff;
      wr_en = 1'b0; refresh = 1'b0; wr_idx = free_idx;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && q_ready) begin
               case (q_item.op)
                  CMD_OBSERVE: begin
                     if (hit != '0) refresh = 1'b1;
                     else begin
                        ev_valid_in = 1'b1;
                        ev_in = '{kind: free_found ? KIND_DISCOVERED : KIND_FULL,
                                  mac: q_item.mac, port: q_item.port, last: 1'b1};
                        if (free_found) begin
                           wr_en = 1'b1;
                           valid_in[free_idx] = 1'b1;
                        end
                     end
                  end
                  CMD_TICK: begin
                     time_in = time_ff + 32'd1;
                     cur_in = q_item; idx_in = '0; pend_in = 1'b0; state_in = ST_SWEEP;
                  end
                  CMD_REMOVE: begin
                     cur_in = q_item; idx_in = '0; pend_in = 1'b0; state_in = ST_SWEEP;
                  end
                  default: ;
               endcase
            end
         end
         ST_SWEEP: begin
            // one entry a cycle while the output is free; hold a found event until the next one shows
            // whether it is the last
            if (out_free) begin
               if (match) begin
                  valid_in[idx_ff] = 1'b0;
                  pend_in = 1'b1;
                  pev_in = '{kind: KIND_DISAPPEARED, mac: emac_ff[idx_ff],
                             port: eport_ff[idx_ff], last: 1'b0};
                  if (pend_ff) begin
                     ev_valid_in = 1'b1; ev_in = pev_ff;
                  end
               end
               if (idx_ff == IDX_W'(TABLE_DEPTH - 1)) begin
                  state_in = ST_IDLE;
                  pend_in = 1'b0;
                  if (match) begin
                     ev_valid_in = 1'b1;
                     ev_in = pev_in; ev_in.last = 1'b1;
                     if (pend_ff) begin
                        // two to emit: emit earlier, keep last pending
                        ev_in = pev_ff;
                        pend_in = 1'b1; state_in = ST_FLUSH;
                     end
                  end else if (pend_ff) begin
                     ev_valid_in = 1'b1; ev_in = pev_ff; ev_in.last = 1'b1;
                  end
               end else idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_FLUSH: begin
            // flush the final held event
            if (out_free) begin
               ev_valid_in = 1'b1; ev_in = pev_ff; ev_in.last = 1'b1;
               pend_in = 1'b0; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         emac_ff[wr_idx]  <= q_item.mac;
         eport_ff[wr_idx] <= q_item.port;
      end
      if (wr_en) etime_ff[wr_idx] <= time_ff;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (refresh && hit[i]) etime_ff[i] <= time_ff;
      cur_ff <= cur_in; pev_ff <= pev_in; ev_ff <= ev_in; idx_ff <= idx_in;
      if (reset) begin
         valid_ff <= '0; time_ff <= '0; state_ff <= ST_IDLE;
         pend_ff <= 1'b0; ev_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in; time_ff <= time_in; state_ff <= state_in;
         pend_ff <= pend_in; ev_valid_ff <= ev_valid_in;
      end
   end

   assign ev_valid = ev_valid_ff;
   assign ev = ev_ff;
endmodule

// File: hw/rtl/mac_learning_table_aging_unit.sv
// MAC learning table with aging.
// req channel: tdata = {port[53:50], mac[49:2], command[1:0]}, zero padded to 56 bits.
// Observe learns (mac, port) pairs, tick advances time and ages out stale
// entries, remove drops every entry of one port.
// rsp channel: tdata = {event_port, event_mac, event_kind}; tlast marks the final
// event of one request. Requests that cause no event produce no transaction.
// csr port: write enable, register index and 48-bit data, no read-back.
// A two-entry queue between the classifier and the table engine decouples them.
// Observe passes through the queue and the engine (match over all entries in parallel,
// then update); its event appears in the cycle after the engine takes it.
// Tick and remove sweep the table one entry a cycle while the response side is free;
// the engine takes no new request until it is back in idle.
// Reset (synchronous) empties the table, zeroes the time counter and restores
// register defaults. When rsp_tready is low with an event waiting the engine holds; the queue keeps
// accepting until full, then req_tready drops.
module mac_learning_table_aging_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // command[1:0], mac[49:2], port[53:50]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // event_kind[1:0], event_mac[49:2], event_port[53:50]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);
   import mlta_pkg::*;

   logic        q_valid, q_ready;
   work_type    q_item;
   logic [31:0] max_age;
   event_type   ev;

   mlta_front u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata,
      .q_valid, .q_ready, .q_item, .max_age
   );

   mlta_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_item, .max_age,
      .ev_valid(rsp_tvalid), .ev_ready(rsp_tready), .ev
   );

   assign rsp_tdata = {2'b00, ev.port, ev.mac, ev.kind};
   assign rsp_tlast = ev.last;
endmodule

// File: hw/rtl/mlta_checker.sv
module mlta_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast
);
   import mlta_pkg::*;

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] <= KIND_FULL) else $error("bad event kind");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:54] == 2'b00) else $error("pad bits set");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp dropped while stalled");
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != KIND_DISAPPEARED |-> rsp_tlast)
      else $error("learn event not last");
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rsp after reset");
endmodule

bind mac_learning_table_aging_unit mlta_checker u_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
);
